// ----- rtl/vfcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types, constants and lookup tables of the voxel face cull mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    // Default edge length of a chunk, in voxels
    localparam int CHUNK_EDGE_DEF = 16;

    // Depth of the queue between the classifier and the emitter
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field widths
    localparam int CHUNK_W   = 11;
    localparam int LOCAL_W   = 4;
    localparam int BLOCK_W   = 8;
    localparam int POS_W     = 16;
    localparam int COUNT_W   = 15;
    localparam int NUMBER_W  = 17;
    localparam int NUM_FACES = 6;
    localparam int FACE_W    = 3;
    localparam int STEP_W    = 4;

    // Per face: four vertex results, then six index results
    localparam int CORNERS_PER_FACE = 4;
    localparam int INDICES_PER_FACE = 6;
    localparam int STEPS_PER_FACE   = CORNERS_PER_FACE + INDICES_PER_FACE;

    localparam logic [NUM_FACES-1:0] ALL_FACES = 6'b111111;
    localparam logic [NUM_FACES-1:0] NO_FACES  = 6'b000000;

    // Configuration register indexes
    localparam logic [1:0] REG_CHUNK_X = 2'd0;
    localparam logic [1:0] REG_CHUNK_Y = 2'd1;
    localparam logic [1:0] REG_CHUNK_Z = 2'd2;

    // Neighbour class codes
    localparam logic [1:0] NB_EMPTY      = 2'd0;
    localparam logic [1:0] NB_OPAQUE     = 2'd1;
    localparam logic [1:0] NB_TRANS_SAME = 2'd2;
    localparam logic [1:0] NB_TRANS_DIFF = 2'd3;

    // Result kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    // Face identifiers, named by the neighbour direction they look toward:
    // front z-1, back z+1, left x+1, right x-1, top y+1, bottom y-1
    localparam logic [FACE_W-1:0] FACE_ZNEG = 3'd0;
    localparam logic [FACE_W-1:0] FACE_ZPOS = 3'd1;
    localparam logic [FACE_W-1:0] FACE_XPOS = 3'd2;
    localparam logic [FACE_W-1:0] FACE_XNEG = 3'd3;
    localparam logic [FACE_W-1:0] FACE_YPOS = 3'd4;
    localparam logic [FACE_W-1:0] FACE_YNEG = 3'd5;

    // One classified voxel, passed from classifier to emitter
    typedef struct packed {
        logic                 first;
        logic [BLOCK_W-1:0]   block;
        logic [NUM_FACES-1:0] mask;
        logic [POS_W-1:0]     base_x;
        logic [POS_W-1:0]     base_y;
        logic [POS_W-1:0]     base_z;
    } t_entry;

    // A face is visible through an empty or a differing transparent neighbour
    function automatic logic exposed(input logic [1:0] code);
        return (code == NB_EMPTY) || (code == NB_TRANS_DIFF);
    endfunction

    // Unit-cube corner offset {x, y, z} for a face and corner
    function automatic logic [2:0] cube_corner(input logic [FACE_W-1:0] face,
                                               input logic [1:0] corner);
        logic [2:0] r;
        r = 3'b000;
        case (face)
            FACE_ZNEG: begin
                case (corner)
                    2'd0: r = 3'b010;
                    2'd1: r = 3'b000;
                    2'd2: r = 3'b100;
                    default: r = 3'b110;
                endcase
            end
            FACE_ZPOS: begin
                case (corner)
                    2'd0: r = 3'b011;
                    2'd1: r = 3'b001;
                    2'd2: r = 3'b101;
                    default: r = 3'b111;
                endcase
            end
            FACE_XPOS: begin
                case (corner)
                    2'd0: r = 3'b110;
                    2'd1: r = 3'b100;
                    2'd2: r = 3'b101;
                    default: r = 3'b111;
                endcase
            end
            FACE_XNEG: begin
                case (corner)
                    2'd0: r = 3'b010;
                    2'd1: r = 3'b000;
                    2'd2: r = 3'b001;
                    default: r = 3'b011;
                endcase
            end
            FACE_YPOS: begin
                case (corner)
                    2'd0: r = 3'b011;
                    2'd1: r = 3'b010;
                    2'd2: r = 3'b110;
                    default: r = 3'b111;
                endcase
            end
            default: begin
                case (corner)
                    2'd0: r = 3'b001;
                    2'd1: r = 3'b000;
                    2'd2: r = 3'b100;
                    default: r = 3'b101;
                endcase
            end
        endcase
        return r;
    endfunction

    // Winding table: corner referenced by each index of a face.
    // Front, left and top share one winding; right and bottom another.
    function automatic logic [1:0] winding(input logic [FACE_W-1:0] face,
                                           input logic [2:0] idx);
        logic [1:0] r;
        r = 2'd0;
        case (face)
            FACE_ZPOS: begin
                case (idx)
                    3'd0: r = 2'd1;
                    3'd1: r = 2'd2;
                    3'd2: r = 2'd0;
                    3'd3: r = 2'd3;
                    3'd4: r = 2'd0;
                    default: r = 2'd2;
                endcase
            end
            FACE_XNEG, FACE_YNEG: begin
                case (idx)
                    3'd0: r = 2'd3;
                    3'd1: r = 2'd0;
                    3'd2: r = 2'd2;
                    3'd3: r = 2'd1;
                    3'd4: r = 2'd2;
                    default: r = 2'd0;
                endcase
            end
            default: begin
                case (idx)
                    3'd0: r = 2'd0;
                    3'd1: r = 2'd2;
                    3'd2: r = 2'd1;
                    3'd3: r = 2'd2;
                    3'd4: r = 2'd0;
                    default: r = 2'd3;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/vfcm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_front
// Classifier: takes one voxel, builds its visible-face mask and the world
// base position, and holds the result in a register for the queue.
// ----------------------------------------------------------------------------
module vfcm_front
    import vfcm_pkg::*;
#(
    parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_first_voxel,
    input  logic [BLOCK_W-1:0] i_block_type,
    input  logic               i_internal_faces,
    input  logic [LOCAL_W-1:0] i_voxel_x,
    input  logic [LOCAL_W-1:0] i_voxel_y,
    input  logic [LOCAL_W-1:0] i_voxel_z,
    input  logic [1:0]         i_nb_above,
    input  logic [1:0]         i_nb_below,
    input  logic [1:0]         i_nb_zminus,
    input  logic [1:0]         i_nb_zplus,
    input  logic [1:0]         i_nb_xplus,
    input  logic [1:0]         i_nb_xminus,
    input  logic [CHUNK_W-1:0] i_chunk_x,
    input  logic [CHUNK_W-1:0] i_chunk_y,
    input  logic [CHUNK_W-1:0] i_chunk_z,
    output logic               o_valid,
    output t_entry             o_entry,
    input  logic               i_ready
);

    localparam logic [POS_W-1:0] EDGE = POS_W'(CHUNK_EDGE);

    logic                 r_valid;
    logic                 n_valid;
    t_entry               r_entry;
    t_entry               n_entry;
    logic [NUM_FACES-1:0] mask;
    logic                 accept;
    logic [2*POS_W-1:0]   prod_x;
    logic [2*POS_W-1:0]   prod_y;
    logic [2*POS_W-1:0]   prod_z;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    // Visible faces; bit order front, back, left, right, top, bottom
    always_comb begin
        if (i_block_type == '0) begin
            mask = NO_FACES;
        end else if (i_internal_faces) begin
            mask = ALL_FACES;
        end else begin
            mask = {exposed(i_nb_below), exposed(i_nb_above),
                    exposed(i_nb_xminus), exposed(i_nb_xplus),
                    exposed(i_nb_zplus), exposed(i_nb_zminus)};
        end
    end

    // World base = chunk * edge + local, modulo 2^16
    assign prod_x = {{(POS_W-CHUNK_W){i_chunk_x[CHUNK_W-1]}}, i_chunk_x} * EDGE;
    assign prod_y = {{(POS_W-CHUNK_W){i_chunk_y[CHUNK_W-1]}}, i_chunk_y} * EDGE;
    assign prod_z = {{(POS_W-CHUNK_W){i_chunk_z[CHUNK_W-1]}}, i_chunk_z} * EDGE;

    always_comb begin
        n_entry.first  = i_first_voxel;
        n_entry.block  = i_block_type;
        n_entry.mask   = mask;
        n_entry.base_x = prod_x[POS_W-1:0] + {{(POS_W-LOCAL_W){1'b0}}, i_voxel_x};
        n_entry.base_y = prod_y[POS_W-1:0] + {{(POS_W-LOCAL_W){1'b0}}, i_voxel_y};
        n_entry.base_z = prod_z[POS_W-1:0] + {{(POS_W-LOCAL_W){1'b0}}, i_voxel_z};
    end

    // Voxels that neither emit nor clear the counter are dropped here
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = i_first_voxel || (mask != NO_FACES);
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

// ----- rtl/vfcm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_queue
// Small register queue of classified voxels between classifier and emitter.
// ----------------------------------------------------------------------------
module vfcm_queue
    import vfcm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push_en;
    logic               pop_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && o_valid;

    // Pointers wrap at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + 1'b1;
            end else if (pop_en && !push_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- rtl/vfcm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_back
// Emitter: walks the visible faces of one voxel, ten results per face, and
// keeps the face counter. Results leave through an output register.
// ----------------------------------------------------------------------------
module vfcm_back
    import vfcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_entry              i_entry,
    output logic                o_take,
    output logic                o_empty,
    input  logic                i_pop,
    output logic                o_kind,
    output logic [FACE_W-1:0]   o_face_id,
    output logic [1:0]          o_corner,
    output logic [BLOCK_W-1:0]  o_block_tag,
    output logic [POS_W-1:0]    o_pos_x,
    output logic [POS_W-1:0]    o_pos_y,
    output logic [POS_W-1:0]    o_pos_z,
    output logic [NUMBER_W-1:0] o_number,
    output logic                o_last
);

    // Working voxel
    logic                 r_busy;
    logic [NUM_FACES-1:0] r_mask;
    logic [STEP_W-1:0]    r_step;
    logic [BLOCK_W-1:0]   r_block;
    logic [POS_W-1:0]     r_base_x;
    logic [POS_W-1:0]     r_base_y;
    logic [POS_W-1:0]     r_base_z;
    logic [COUNT_W-1:0]   r_counter;
    logic [COUNT_W-1:0]   n_counter;

    // Output register
    logic                 r_out_valid;
    logic                 r_kind;
    logic [FACE_W-1:0]    r_face_id;
    logic [1:0]           r_corner;
    logic [BLOCK_W-1:0]   r_block_tag;
    logic [POS_W-1:0]     r_pos_x;
    logic [POS_W-1:0]     r_pos_y;
    logic [POS_W-1:0]     r_pos_z;
    logic [NUMBER_W-1:0]  r_number;
    logic                 r_last;

    logic                 out_ready;
    logic                 emit;
    logic                 face_done;
    logic                 is_last;
    logic                 load;
    logic [FACE_W-1:0]    face;
    logic [NUM_FACES-1:0] face_bit;
    logic [NUM_FACES-1:0] rest_mask;
    logic                 is_vertex;
    logic [1:0]           corner;
    logic [2:0]           offs;
    logic [STEP_W-1:0]    idx_step;

    // Lowest remaining face
    always_comb begin
        face = FACE_W'(NUM_FACES - 1);
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                face = FACE_W'(i);
            end
        end
    end

    assign face_bit  = NUM_FACES'(1) << face;
    assign rest_mask = r_mask & ~face_bit;

    assign out_ready = !r_out_valid || i_pop;
    assign emit      = r_busy && out_ready;
    assign face_done = (r_step == STEP_W'(STEPS_PER_FACE - 1));
    assign is_last   = face_done && (rest_mask == NO_FACES);
    assign load      = i_valid && (!r_busy || (emit && is_last));
    assign o_take    = load;

    // Result fields of the current step
    assign is_vertex = (r_step < STEP_W'(CORNERS_PER_FACE));
    assign idx_step  = r_step - STEP_W'(CORNERS_PER_FACE);
    assign corner    = is_vertex ? r_step[1:0] : winding(face, idx_step[2:0]);
    assign offs      = cube_corner(face, corner);

    // Face counter: a first voxel clears it before its own faces
    always_comb begin
        n_counter = r_counter;
        if (emit && face_done) begin
            n_counter = r_counter + 1'b1;
        end
        if (load && i_entry.first) begin
            n_counter = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mask      <= NO_FACES;
            r_step      <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_counter <= n_counter;
            if (load) begin
                r_busy <= (i_entry.mask != NO_FACES);
                r_mask <= i_entry.mask;
                r_step <= '0;
            end else if (emit) begin
                if (face_done) begin
                    r_step <= '0;
                    r_mask <= rest_mask;
                    r_busy <= !is_last;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Voxel payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_block  <= i_entry.block;
            r_base_x <= i_entry.base_x;
            r_base_y <= i_entry.base_y;
            r_base_z <= i_entry.base_z;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind      <= is_vertex ? KIND_VERTEX : KIND_INDEX;
            r_face_id   <= face;
            r_corner    <= corner;
            r_block_tag <= r_block;
            r_pos_x     <= is_vertex ? r_base_x + {{(POS_W-1){1'b0}}, offs[2]} : '0;
            r_pos_y     <= is_vertex ? r_base_y + {{(POS_W-1){1'b0}}, offs[1]} : '0;
            r_pos_z     <= is_vertex ? r_base_z + {{(POS_W-1){1'b0}}, offs[0]} : '0;
            r_number    <= {r_counter, 2'b00} + {{(NUMBER_W-2){1'b0}}, corner};
            r_last      <= is_last;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_kind      = r_kind;
    assign o_face_id   = r_face_id;
    assign o_corner    = r_corner;
    assign o_block_tag = r_block_tag;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_pos_z     = r_pos_z;
    assign o_number    = r_number;
    assign o_last      = r_last;

    // A busy emitter always has a face left to walk
    a_busy_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != NO_FACES))
        else $error("emitter busy with empty face mask");

    // The step counter stays within one face
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < STEP_W'(STEPS_PER_FACE))
        else $error("emitter step out of range");

    // Finishing a face advances the counter unless a first voxel clears it
    a_counter_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && face_done && !(load && i_entry.first))
            |=> (r_counter == $past(r_counter) + 1'b1))
        else $error("face counter did not advance");

    // A new voxel is taken only after the last result of the previous one
    a_load_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_busy) |-> (emit && is_last))
        else $error("voxel loaded while previous one still emitting");

endmodule

// ----- rtl/voxel_face_cull_mesher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher_core
// Face-culling mesher: one voxel in, four vertices and six indices out per
// visible face. Classifier and emitter are decoupled by a short queue.
// ----------------------------------------------------------------------------
// Path: a voxel passes the classifier register, the queue, the emitter
//   registers and the output register. Throughput: one result per cycle
//   from the emitter while results are popped; a fully hidden voxel with
//   first_voxel set still reaches the emitter, other air or hidden voxels
//   are dropped. Input takes a voxel every cycle while the queue has room.
// Reset: synchronous, active low; clears queue, face counter and chunk regs.
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher_core
    import vfcm_pkg::*;
#(
    parameter int CHUNK_EDGE  = CHUNK_EDGE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // voxel input
    input  logic                push,
    output logic                full,
    input  logic                i_first_voxel,
    input  logic [BLOCK_W-1:0]  i_block_type,
    input  logic                i_internal_faces,
    input  logic [LOCAL_W-1:0]  i_voxel_x,
    input  logic [LOCAL_W-1:0]  i_voxel_y,
    input  logic [LOCAL_W-1:0]  i_voxel_z,
    input  logic [1:0]          i_nb_above,
    input  logic [1:0]          i_nb_below,
    input  logic [1:0]          i_nb_zminus,
    input  logic [1:0]          i_nb_zplus,
    input  logic [1:0]          i_nb_xplus,
    input  logic [1:0]          i_nb_xminus,
    // results
    output logic                empty,
    input  logic                pop,
    output logic                o_kind,
    output logic [FACE_W-1:0]   o_face_id,
    output logic [1:0]          o_corner,
    output logic [BLOCK_W-1:0]  o_block_tag,
    output logic [POS_W-1:0]    o_pos_x,
    output logic [POS_W-1:0]    o_pos_y,
    output logic [POS_W-1:0]    o_pos_z,
    output logic [NUMBER_W-1:0] o_number,
    output logic                o_last
);

    logic [CHUNK_W-1:0] r_chunk_x;
    logic [CHUNK_W-1:0] r_chunk_y;
    logic [CHUNK_W-1:0] r_chunk_z;
    logic               cfg_wr;
    logic               front_ready;
    logic               front_valid;
    t_entry             front_entry;
    logic               q_full;
    logic               q_valid;
    t_entry             q_entry;
    logic               q_take;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_x <= '0;
            r_chunk_y <= '0;
            r_chunk_z <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_CHUNK_X: r_chunk_x <= pwdata[CHUNK_W-1:0];
                REG_CHUNK_Y: r_chunk_y <= pwdata[CHUNK_W-1:0];
                REG_CHUNK_Z: r_chunk_z <= pwdata[CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_CHUNK_X: prdata = {{(32-CHUNK_W){1'b0}}, r_chunk_x};
            REG_CHUNK_Y: prdata = {{(32-CHUNK_W){1'b0}}, r_chunk_y};
            REG_CHUNK_Z: prdata = {{(32-CHUNK_W){1'b0}}, r_chunk_z};
            default:     prdata = '0;
        endcase
    end

    assign full = !front_ready;

    // Classifier
    vfcm_front #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (push),
        .o_ready          (front_ready),
        .i_first_voxel    (i_first_voxel),
        .i_block_type     (i_block_type),
        .i_internal_faces (i_internal_faces),
        .i_voxel_x        (i_voxel_x),
        .i_voxel_y        (i_voxel_y),
        .i_voxel_z        (i_voxel_z),
        .i_nb_above       (i_nb_above),
        .i_nb_below       (i_nb_below),
        .i_nb_zminus      (i_nb_zminus),
        .i_nb_zplus       (i_nb_zplus),
        .i_nb_xplus       (i_nb_xplus),
        .i_nb_xminus      (i_nb_xminus),
        .i_chunk_x        (r_chunk_x),
        .i_chunk_y        (r_chunk_y),
        .i_chunk_z        (r_chunk_z),
        .o_valid          (front_valid),
        .o_entry          (front_entry),
        .i_ready          (!q_full)
    );

    // Queue of classified voxels
    vfcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_take),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Emitter
    vfcm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_entry     (q_entry),
        .o_take      (q_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_kind      (o_kind),
        .o_face_id   (o_face_id),
        .o_corner    (o_corner),
        .o_block_tag (o_block_tag),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_number    (o_number),
        .o_last      (o_last)
    );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voxel face cull mesher. Voxels are pushed
// through the input queue port and every popped vertex/index transaction is
// matched against a mesh predictor kept inside the bench. The chunk location
// registers are reprogrammed between phases over the APB port; the run covers
// directed corner cases and random voxels, one phase without any stalls.
// ----------------------------------------------------------------------------
module testbench;
    import vfcm_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_LEN   = 9;
    localparam int IDLE_PCT    = 32;
    localparam int SETTLE      = 16;
    localparam int RAND_ITEMS  = 51;            // per random phase, four phases
    localparam int CYCLE_LIMIT = 2_000_000;

    // Unit-cube corner offset {x, y, z} per face and corner
    localparam bit [2:0] CORNER_OFS [NUM_FACES][CORNERS_PER_FACE] = '{
        '{3'b010, 3'b000, 3'b100, 3'b110},
        '{3'b011, 3'b001, 3'b101, 3'b111},
        '{3'b110, 3'b100, 3'b101, 3'b111},
        '{3'b010, 3'b000, 3'b001, 3'b011},
        '{3'b011, 3'b010, 3'b110, 3'b111},
        '{3'b001, 3'b000, 3'b100, 3'b101}
    };

    // Corner referenced by each of the six indices of a face
    localparam bit [1:0] WIND [NUM_FACES][INDICES_PER_FACE] = '{
        '{2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd3},
        '{2'd1, 2'd2, 2'd0, 2'd3, 2'd0, 2'd2},
        '{2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1, 2'd2, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1, 2'd2, 2'd0}
    };

    typedef struct packed {
        logic               first;
        logic [BLOCK_W-1:0] block;
        logic               show_inner;
        logic [LOCAL_W-1:0] x;
        logic [LOCAL_W-1:0] y;
        logic [LOCAL_W-1:0] z;
        logic [1:0]         above;
        logic [1:0]         below;
        logic [1:0]         zminus;
        logic [1:0]         zplus;
        logic [1:0]         xplus;
        logic [1:0]         xminus;
    } t_voxel;

    typedef struct packed {
        logic                kind;
        logic [FACE_W-1:0]   face;
        logic [1:0]          corner;
        logic [BLOCK_W-1:0]  block;
        logic [POS_W-1:0]    px;
        logic [POS_W-1:0]    py;
        logic [POS_W-1:0]    pz;
        logic [NUMBER_W-1:0] number;
        logic                last;
    } t_mesh_result;

    // ------------------------------------------------------------------------
    // Mesh predictor: chunk registers, face counter and the queue of
    // vertex/index transactions still owed by the block
    // ------------------------------------------------------------------------
    class mesh_predictor;
        logic signed [CHUNK_W-1:0] chunk [3];
        logic [COUNT_W-1:0]        face_count;
        t_mesh_result              owed_mesh [$];
        int unsigned               mismatches;

        function new();
            chunk      = '{default: '0};
            face_count = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed_mesh.size();
        endfunction

        function bit shows_face(logic [1:0] code);
            return code == NB_EMPTY || code == NB_TRANS_DIFF;
        endfunction

        function void report(string msg);
            mismatches++;
            $error("%s", msg);
        endfunction

        function void cmp(string name, longint expv, longint gotv);
            if (expv != gotv) begin
                report($sformatf("%s: expected %0d, got %0d", name, expv, gotv));
            end
        endfunction

        // Expected transactions for one accepted voxel
        function void take_voxel(t_voxel v);
            logic [NUM_FACES-1:0] mask;
            logic [POS_W-1:0]     base [3];
            logic [LOCAL_W-1:0]   loc [3];
            logic [NUMBER_W-1:0]  offset;
            t_mesh_result         r;
            int                   w;
            if (v.first) begin
                face_count = '0;
            end
            if (v.block == '0) begin
                return;
            end
            if (v.show_inner) begin
                mask = ALL_FACES;
            end else begin
                mask = NO_FACES;
                mask[FACE_ZNEG] = shows_face(v.zminus);
                mask[FACE_ZPOS] = shows_face(v.zplus);
                mask[FACE_XPOS] = shows_face(v.xplus);
                mask[FACE_XNEG] = shows_face(v.xminus);
                mask[FACE_YPOS] = shows_face(v.above);
                mask[FACE_YNEG] = shows_face(v.below);
            end
            if (mask == NO_FACES) begin
                return;
            end
            loc = '{v.x, v.y, v.z};
            for (int a = 0; a < 3; a++) begin
                w = int'(chunk[a]) * CHUNK_EDGE_DEF + int'(loc[a]);
                base[a] = w[POS_W-1:0];
            end
            for (int f = 0; f < NUM_FACES; f++) begin
                if (mask[f]) begin
                    offset = {face_count, 2'b00};
                    for (int k = 0; k < CORNERS_PER_FACE; k++) begin
                        r.kind   = KIND_VERTEX;
                        r.face   = FACE_W'(f);
                        r.corner = 2'(k);
                        r.block  = v.block;
                        r.px     = base[0] + POS_W'(CORNER_OFS[f][k][2]);
                        r.py     = base[1] + POS_W'(CORNER_OFS[f][k][1]);
                        r.pz     = base[2] + POS_W'(CORNER_OFS[f][k][0]);
                        r.number = offset + NUMBER_W'(k);
                        r.last   = 1'b0;
                        owed_mesh.insert(owed_mesh.size(), r);
                    end
                    for (int k = 0; k < INDICES_PER_FACE; k++) begin
                        r.kind   = KIND_INDEX;
                        r.face   = FACE_W'(f);
                        r.corner = WIND[f][k];
                        r.block  = v.block;
                        r.px     = '0;
                        r.py     = '0;
                        r.pz     = '0;
                        r.number = offset + NUMBER_W'(WIND[f][k]);
                        r.last   = 1'b0;
                        owed_mesh.insert(owed_mesh.size(), r);
                    end
                    face_count = face_count + 1'b1;
                end
            end
            owed_mesh[owed_mesh.size()-1].last = 1'b1;
        endfunction

        // Compare one popped transaction with the oldest one owed
        function void match_result(t_mesh_result got);
            t_mesh_result e;
            if (owed_mesh.size() == 0) begin
                report("result popped with nothing outstanding");
                return;
            end
            e = owed_mesh.pop_front();
            cmp("kind", e.kind, got.kind);
            cmp("face_id", e.face, got.face);
            cmp("corner", e.corner, got.corner);
            cmp("block_tag", e.block, got.block);
            cmp("pos_x", longint'($signed(e.px)), longint'($signed(got.px)));
            cmp("pos_y", longint'($signed(e.py)), longint'($signed(got.py)));
            cmp("pos_z", longint'($signed(e.pz)), longint'($signed(got.pz)));
            cmp("number", e.number, got.number);
            cmp("last", e.last, got.last);
        endfunction
    endclass

    // DUT signals
    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                push;
    logic                full;
    logic                i_first_voxel;
    logic [BLOCK_W-1:0]  i_block_type;
    logic                i_internal_faces;
    logic [LOCAL_W-1:0]  i_voxel_x;
    logic [LOCAL_W-1:0]  i_voxel_y;
    logic [LOCAL_W-1:0]  i_voxel_z;
    logic [1:0]          i_nb_above;
    logic [1:0]          i_nb_below;
    logic [1:0]          i_nb_zminus;
    logic [1:0]          i_nb_zplus;
    logic [1:0]          i_nb_xplus;
    logic [1:0]          i_nb_xminus;
    logic                empty;
    logic                pop;
    logic                o_kind;
    logic [FACE_W-1:0]   o_face_id;
    logic [1:0]          o_corner;
    logic [BLOCK_W-1:0]  o_block_tag;
    logic [POS_W-1:0]    o_pos_x;
    logic [POS_W-1:0]    o_pos_y;
    logic [POS_W-1:0]    o_pos_z;
    logic [NUMBER_W-1:0] o_number;
    logic                o_last;

    mesh_predictor pred;
    bit            calm;          // no idling on either side while set
    int unsigned   cycles;

    voxel_face_cull_mesher_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .i_first_voxel    (i_first_voxel),
        .i_block_type     (i_block_type),
        .i_internal_faces (i_internal_faces),
        .i_voxel_x        (i_voxel_x),
        .i_voxel_y        (i_voxel_y),
        .i_voxel_z        (i_voxel_z),
        .i_nb_above       (i_nb_above),
        .i_nb_below       (i_nb_below),
        .i_nb_zminus      (i_nb_zminus),
        .i_nb_zplus       (i_nb_zplus),
        .i_nb_xplus       (i_nb_xplus),
        .i_nb_xminus      (i_nb_xminus),
        .empty            (empty),
        .pop              (pop),
        .o_kind           (o_kind),
        .o_face_id        (o_face_id),
        .o_corner         (o_corner),
        .o_block_tag      (o_block_tag),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_pos_z          (o_pos_z),
        .o_number         (o_number),
        .o_last           (o_last)
    );

    // Clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random pop stalls
    always @(negedge i_clk) begin
        pop = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            pred.match_result({o_kind, o_face_id, o_corner, o_block_tag,
                               o_pos_x, o_pos_y, o_pos_z, o_number, o_last});
        end
    end

    // APB write of one chunk register
    task automatic write_chunk(logic [1:0] idx, logic signed [CHUNK_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = 32'(val);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        pred.chunk[idx] = val;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_chunks(logic signed [CHUNK_W-1:0] cx,
                              logic signed [CHUNK_W-1:0] cy,
                              logic signed [CHUNK_W-1:0] cz);
        write_chunk(REG_CHUNK_X, cx);
        write_chunk(REG_CHUNK_Y, cy);
        write_chunk(REG_CHUNK_Z, cz);
    endtask

    // Push one voxel; returns at the edge where the transaction is accepted
    task automatic send_voxel(t_voxel v);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge i_clk);
            push = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_first_voxel    = v.first;
        i_block_type     = v.block;
        i_internal_faces = v.show_inner;
        i_voxel_x        = v.x;
        i_voxel_y        = v.y;
        i_voxel_z        = v.z;
        i_nb_above       = v.above;
        i_nb_below       = v.below;
        i_nb_zminus      = v.zminus;
        i_nb_zplus       = v.zplus;
        i_nb_xplus       = v.xplus;
        i_nb_xminus      = v.xminus;
        push             = 1'b1;
        do @(posedge i_clk); while (full);
        pred.take_voxel(v);
    endtask

    // Stop pushing, wait for all owed results, then let the pipe go quiet
    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        while (pred.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_voxel make_voxel(bit first, logic [BLOCK_W-1:0] block,
                                          bit inner, logic [LOCAL_W-1:0] c,
                                          logic [1:0] nb);
        t_voxel v;
        v = '{first, block, inner, c, c, c, nb, nb, nb, nb, nb, nb};
        return v;
    endfunction

    // Mostly hidden neighbours, every class code reachable
    function automatic logic [1:0] random_class();
        return ($urandom_range(0, 2) == 0) ? NB_OPAQUE : 2'($urandom_range(0, 3));
    endfunction

    function automatic t_voxel random_voxel();
        t_voxel v;
        v.first      = ($urandom_range(0, 99) < 6);
        v.block      = ($urandom_range(0, 99) < 8) ? '0 : BLOCK_W'($urandom_range(1, 255));
        v.show_inner = ($urandom_range(0, 99) < 15);
        v.x          = LOCAL_W'($urandom_range(0, 15));
        v.y          = LOCAL_W'($urandom_range(0, 15));
        v.z          = LOCAL_W'($urandom_range(0, 15));
        v.above      = random_class();
        v.below      = random_class();
        v.zminus     = random_class();
        v.zplus      = random_class();
        v.xplus      = random_class();
        v.xminus     = random_class();
        return v;
    endfunction

    function automatic logic signed [CHUNK_W-1:0] random_chunk();
        return CHUNK_W'($urandom_range(0, 2047));
    endfunction

    // Stimulus
    initial begin
        t_voxel v;
        pred             = new();
        calm             = 1'b0;
        cycles           = 0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        push             = 1'b0;
        pop              = 1'b0;
        i_first_voxel    = 1'b0;
        i_block_type     = '0;
        i_internal_faces = 1'b0;
        i_voxel_x        = '0;
        i_voxel_y        = '0;
        i_voxel_z        = '0;
        i_nb_above       = NB_EMPTY;
        i_nb_below       = NB_EMPTY;
        i_nb_zminus      = NB_EMPTY;
        i_nb_zplus       = NB_EMPTY;
        i_nb_xplus       = NB_EMPTY;
        i_nb_xminus      = NB_EMPTY;

        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, air, hidden blocks, internal faces, each face alone
        set_chunks('0, '0, '0);
        send_voxel(make_voxel(1'b1, 8'd1, 1'b0, 4'd0, NB_EMPTY));
        send_voxel(make_voxel(1'b0, 8'd255, 1'b0, 4'd15, NB_TRANS_DIFF));
        send_voxel(make_voxel(1'b0, 8'd0, 1'b0, 4'd5, NB_EMPTY));
        send_voxel(make_voxel(1'b1, 8'd0, 1'b1, 4'd7, NB_EMPTY));
        send_voxel(make_voxel(1'b0, 8'd42, 1'b0, 4'd3, NB_OPAQUE));
        send_voxel(make_voxel(1'b0, 8'd170, 1'b0, 4'd12, NB_TRANS_SAME));
        send_voxel(make_voxel(1'b0, 8'd85, 1'b1, 4'd9, NB_OPAQUE));
        for (int f = 0; f < NUM_FACES; f++) begin
            v = make_voxel(1'b0, 8'(f + 10), 1'b0, 4'(f), NB_OPAQUE);
            case (f)
                FACE_ZNEG: v.zminus = NB_EMPTY;
                FACE_ZPOS: v.zplus  = NB_TRANS_DIFF;
                FACE_XPOS: v.xplus  = NB_EMPTY;
                FACE_XNEG: v.xminus = NB_TRANS_DIFF;
                FACE_YPOS: v.above  = NB_EMPTY;
                default:   v.below  = NB_TRANS_DIFF;
            endcase
            send_voxel(v);
        end
        v = make_voxel(1'b1, 8'd128, 1'b0, 4'd8, NB_OPAQUE);
        v.zminus = NB_TRANS_DIFF;
        v.xplus  = NB_TRANS_SAME;
        v.above  = NB_EMPTY;
        send_voxel(v);
        // hidden block that still clears the counter
        send_voxel(make_voxel(1'b1, 8'd77, 1'b0, 4'd1, NB_TRANS_SAME));
        send_voxel(make_voxel(1'b0, 8'd2, 1'b0, 4'd14, NB_EMPTY));
        drain();

        // Random phases over several chunk locations; the third runs without stalls
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       set_chunks(-11'sd1024, -11'sd1024, -11'sd1024);
                1:       set_chunks(11'sd1023, 11'sd1023, 11'sd1023);
                2:       set_chunks(random_chunk(), random_chunk(), random_chunk());
                default: set_chunks(11'sd1023, -11'sd1024, random_chunk());
            endcase
            calm = (p == 2);
            repeat (RAND_ITEMS) send_voxel(random_voxel());
            drain();
        end
        calm = 1'b0;

        if (pred.mismatches == 0 && pred.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
